// ===== design/breit_wigner_mass_sampler_assert.svh =====
// Assertion macros for the Breit-Wigner mass sampler checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef BREIT_WIGNER_MASS_SAMPLER_ASSERT_SVH
`define BREIT_WIGNER_MASS_SAMPLER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BWMS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define BWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bwms_pkg.sv =====
// Shared types, constants and the arctangent table builder of the mass sampler.
// Depends on nothing; the sampler and its testbench use it.
`default_nettype none

package bwms_pkg;

   // pi/4 with 62 fraction bits
   localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;

   // quotient bits of the two long divisions, and the normalize steps
   localparam int Q1_BITS    = 26;
   localparam int Q2_BITS    = 24;
   localparam int NORM_STEPS = 6;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_SAT    = 2'd2,
      ST_ZERO_W = 2'd3
   } status_type;

   // per-item fields that ride along the whole pipeline
   typedef struct packed {
      logic [23:0] mn;
      logic [23:0] mx;
      logic [23:0] pk;
      logic [23:0] wd;
      logic [23:0] u;
      logic        neg;
      logic        early;
      logic [23:0] e_mass;
      status_type  e_stat;
   } side_type;

   // atan(2^-idx) with frac fraction bits, from the series at 62 fraction bits
   function automatic logic [63:0] atan_entry(input int unsigned idx,
                                              input int unsigned frac);
      logic [63:0] v;
      logic [63:0] term;
      logic [63:0] sh;
      logic        done;
      v    = 64'd0;
      done = 1'b0;
      if (idx == 0) begin
         v = PI_QUARTER_Q62;
      end else begin
         for (int unsigned k = 0; k < 64; k++) begin
            sh = 64'(idx) * 64'(2 * k + 1);
            if (sh >= 64'd63) begin
               done = 1'b1;
            end
            if (!done) begin
               term = ((64'd1 << 62) >> sh) / 64'(2 * k + 1);
               if (k[0]) begin
                  v = v - term;
               end else begin
                  v = v + term;
               end
            end
         end
      end
      return (v + (64'd1 << (61 - frac))) >> (62 - frac);
   endfunction

endpackage

`default_nettype wire

// ===== design/bwms_if.sv =====
// Valid/ready channel interfaces for the mass sampler request and response words.
// Depends on nothing.
`default_nettype none

interface bwms_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] min_mass;
   logic [23:0] max_mass;
   logic [23:0] peak_mass;
   logic [23:0] full_width;
   logic [23:0] uniform_draw;

   modport source (output valid, min_mass, max_mass, peak_mass, full_width,
                   uniform_draw, input ready);
   modport sink (input valid, min_mass, max_mass, peak_mass, full_width,
                 uniform_draw, output ready);
endinterface

interface bwms_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] sampled_mass;
   logic [1:0]  status;

   modport source (output valid, sampled_mass, status, input ready);
   modport sink (input valid, sampled_mass, status, output ready);
endinterface

`default_nettype wire

// ===== design/breit_wigner_mass_sampler.sv =====
// Truncated Breit-Wigner mass sampler. Takes one request word per cycle while the output
// queue has room (min, max, peak, width in unsigned Q4.20 and a Q0.24 uniform draw) and
// returns one mass in [min, max] by the inverse CDF, with a status: 0 normal, 1 empty range
// (max returned), 2 saturated to a bound, 3 zero width (peak clamped). Throughput is one word
// per clock while the queue has room. The path runs through the two CORDIC chains of
// ANGLE_STEPS stages each and the 26- and 24-stage long dividers of the offset path. A
// two-entry output queue lets requests keep flowing while a response waits to be taken.
// Depends on bwms_pkg and bwms_if.
`default_nettype none

module breit_wigner_mass_sampler #(
   parameter int FRAC_BITS   = 20,
   parameter int ANGLE_STEPS = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bwms_req_if.sink    req_ch,
   bwms_rsp_if.source  rsp_ch
);

   localparam int ANG_W = FRAC_BITS + 4;
   localparam int N     = ANGLE_STEPS;
   localparam int Q1    = bwms_pkg::Q1_BITS;
   localparam int Q2    = bwms_pkg::Q2_BITS;
   localparam int NS    = bwms_pkg::NORM_STEPS;

   // stage numbers
   localparam int S_SP1 = N + 1;
   localparam int S_SP2 = S_SP1 + 1;
   localparam int S_PR  = S_SP2 + 1;
   localparam int S_TH  = S_PR + 1;
   localparam int S_PH  = S_TH + 1;
   localparam int S_PO  = S_PH + N + 1;
   localparam int S_SC  = S_PO + NS + 1;
   localparam int S_M2  = S_SC + Q1 + 1;
   localparam int S_NU  = S_M2 + 1;
   localparam int S_OF  = S_NU + Q2 + 1;
   localparam int S_MA  = S_OF + 1;
   localparam int S_CL  = S_MA + 1;
   localparam int NST   = S_CL + 1;

   localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'((bwms_pkg::PI_QUARTER_Q62
      + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));

   logic adv;
   logic push;
   logic pop;

   logic [NST-1:0]     vld_ff;
   bwms_pkg::side_type side_ff [NST];
   bwms_pkg::side_type side_in [NST];

   logic signed [63:0]      vxa_ff [0:N];
   logic signed [63:0]      vya_ff [0:N];
   logic signed [ANG_W-1:0] vza_ff [0:N];
   logic signed [63:0]      vxb_ff [0:N];
   logic signed [63:0]      vyb_ff [0:N];
   logic signed [ANG_W-1:0] vzb_ff [0:N];

   logic signed [ANG_W-1:0] dba_ff, dhp_ff, a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [ANG_W-1:0] smin;
   logic [ANG_W-1:0]        sp_ff, th_ff;
   logic [ANG_W+11:0]       ph_ff, pl_ff;
   logic [ANG_W+12:0]       thsum;

   logic signed [63:0]      rx_ff [0:N];
   logic signed [63:0]      ry_ff [0:N];
   logic signed [ANG_W-1:0] rz_ff [0:N];

   logic [63:0] nc_ff [0:NS];
   logic [63:0] nm_ff [0:NS];

   logic [29:0]   d1r_ff [0:Q1];
   logic [Q1-1:0] d1q_ff [0:Q1];
   logic [Q1-1:0] d1m_ff [0:Q1];
   logic [29:0]   d1c_ff [0:Q1];

   logic [49:0] wq_ff;
   logic [53:0] wr_ff;
   logic [29:0] c2_ff;
   logic [54:0] nsum;

   logic [30:0]   d2r_ff [0:Q2];
   logic [Q2-1:0] d2q_ff [0:Q2];
   logic [Q2-1:0] d2n_ff [0:Q2];
   logic [30:0]   d2d_ff [0:Q2];
   logic [48:0]   wqh_ff [0:Q2];

   logic [49:0]        off_ff;
   logic signed [51:0] ms_ff;
   logic [23:0]        fin_mass_ff;
   bwms_pkg::status_type fin_stat_ff;

   logic [23:0]          qm_ff [2];
   bwms_pkg::status_type qs_ff [2];
   logic                 wp_ff, rd_ff;
   logic [1:0]           cnt_ff;

   logic signed [24:0] dmn, dmx;
   logic [23:0]        pk_clamp;

   // advance the whole pipeline while the output queue has room
   assign adv          = (cnt_ff != 2'd2);
   assign req_ch.ready = adv;
   assign push         = adv && vld_ff[NST-1];
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid};
      end
   end

   // side fields: capture, then pass along with early decisions folded in
   always_comb begin
      pk_clamp = (req_ch.peak_mass < req_ch.min_mass) ? req_ch.min_mass :
                 ((req_ch.peak_mass > req_ch.max_mass) ? req_ch.max_mass :
                  req_ch.peak_mass);
      side_in[0].mn     = req_ch.min_mass;
      side_in[0].mx     = req_ch.max_mass;
      side_in[0].pk     = req_ch.peak_mass;
      side_in[0].wd     = req_ch.full_width;
      side_in[0].u      = req_ch.uniform_draw;
      side_in[0].neg    = 1'b0;
      side_in[0].early  = 1'b0;
      side_in[0].e_mass = req_ch.max_mass;
      side_in[0].e_stat = bwms_pkg::ST_OK;
      if (req_ch.max_mass <= req_ch.min_mass) begin
         side_in[0].early  = 1'b1;
         side_in[0].e_stat = bwms_pkg::ST_EMPTY;
      end else if (req_ch.full_width == 24'd0) begin
         side_in[0].early  = 1'b1;
         side_in[0].e_mass = pk_clamp;
         side_in[0].e_stat = bwms_pkg::ST_ZERO_W;
      end
      for (int k = 1; k < NST; k++) begin
         side_in[k] = side_ff[k-1];
      end
      // non-positive cosine saturates toward the sign of the sine
      side_in[S_PO].neg = ry_ff[N][63];
      if (!side_ff[S_PO-1].early && (rx_ff[N] <= 64'sd0)) begin
         side_in[S_PO].early  = 1'b1;
         side_in[S_PO].e_mass = ry_ff[N][63] ? side_ff[S_PO-1].mn : side_ff[S_PO-1].mx;
         side_in[S_PO].e_stat = bwms_pkg::ST_SAT;
      end
      // tangent too large saturates the same way
      if (!side_ff[S_SC-1].early && (nm_ff[NS] >= {nc_ff[NS][63-Q1:0], {Q1{1'b0}}})) begin
         side_in[S_SC].early  = 1'b1;
         side_in[S_SC].e_mass = side_ff[S_SC-1].neg ? side_ff[S_SC-1].mn :
                                side_ff[S_SC-1].mx;
         side_in[S_SC].e_stat = bwms_pkg::ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // load the two vectoring CORDICs with (width, 2(bound-peak)), scaled by 2^30
   assign dmn = $signed({1'b0, req_ch.min_mass}) - $signed({1'b0, req_ch.peak_mass});
   assign dmx = $signed({1'b0, req_ch.max_mass}) - $signed({1'b0, req_ch.peak_mass});

   always_ff @(posedge clock) begin
      if (adv) begin
         vxa_ff[0] <= {10'd0, req_ch.full_width, 30'd0};
         vxb_ff[0] <= {10'd0, req_ch.full_width, 30'd0};
         vya_ff[0] <= {{8{dmn[24]}}, dmn, 31'd0};
         vyb_ff[0] <= {{8{dmx[24]}}, dmx, 31'd0};
         vza_ff[0] <= '0;
         vzb_ff[0] <= '0;
      end
   end

   // vectoring steps: drive y toward zero, collect the angle
   for (genvar i = 0; i < N; i++) begin : g_vec
      localparam logic signed [ANG_W-1:0] TAB =
         ANG_W'(bwms_pkg::atan_entry(i, FRAC_BITS));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (vya_ff[i][63]) begin
               vxa_ff[i+1] <= vxa_ff[i] - (vya_ff[i] >>> i);
               vya_ff[i+1] <= vya_ff[i] + (vxa_ff[i] >>> i);
               vza_ff[i+1] <= vza_ff[i] - TAB;
            end else begin
               vxa_ff[i+1] <= vxa_ff[i] + (vya_ff[i] >>> i);
               vya_ff[i+1] <= vya_ff[i] - (vxa_ff[i] >>> i);
               vza_ff[i+1] <= vza_ff[i] + TAB;
            end
            if (vyb_ff[i][63]) begin
               vxb_ff[i+1] <= vxb_ff[i] - (vyb_ff[i] >>> i);
               vyb_ff[i+1] <= vyb_ff[i] + (vxb_ff[i] >>> i);
               vzb_ff[i+1] <= vzb_ff[i] - TAB;
            end else begin
               vxb_ff[i+1] <= vxb_ff[i] + (vyb_ff[i] >>> i);
               vyb_ff[i+1] <= vyb_ff[i] - (vxb_ff[i] >>> i);
               vzb_ff[i+1] <= vzb_ff[i] + TAB;
            end
         end
      end
   end

   // span = max(0, min(B - A, pi/2 - A)), then theta = span * u
   assign smin  = (dhp_ff < dba_ff) ? dhp_ff : dba_ff;
   assign thsum = (ANG_W+13)'(ph_ff) + (ANG_W+13)'(pl_ff >> 12);

   always_ff @(posedge clock) begin
      if (adv) begin
         dba_ff <= vzb_ff[N] - vza_ff[N];
         dhp_ff <= HALF_PI - vza_ff[N];
         a1_ff  <= vza_ff[N];
         sp_ff  <= smin[ANG_W-1] ? '0 : smin;
         a2_ff  <= a1_ff;
         ph_ff  <= sp_ff * side_ff[S_PR-1].u[23:12];
         pl_ff  <= sp_ff * side_ff[S_PR-1].u[11:0];
         a3_ff  <= a2_ff;
         th_ff  <= thsum[ANG_W+11:12];
         a4_ff  <= a3_ff;
         rx_ff[0] <= 64'sd1 <<< 60;
         ry_ff[0] <= '0;
         rz_ff[0] <= a4_ff + $signed(th_ff);
      end
   end

   // rotation steps: turn (1, 0) by A + theta
   for (genvar j = 0; j < N; j++) begin : g_rot
      localparam logic signed [ANG_W-1:0] TAB =
         ANG_W'(bwms_pkg::atan_entry(j, FRAC_BITS));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!rz_ff[j][ANG_W-1]) begin
               rx_ff[j+1] <= rx_ff[j] - (ry_ff[j] >>> j);
               ry_ff[j+1] <= ry_ff[j] + (rx_ff[j] >>> j);
               rz_ff[j+1] <= rz_ff[j] - TAB;
            end else begin
               rx_ff[j+1] <= rx_ff[j] + (ry_ff[j] >>> j);
               ry_ff[j+1] <= ry_ff[j] - (rx_ff[j] >>> j);
               rz_ff[j+1] <= rz_ff[j] + TAB;
            end
         end
      end
   end

   // take |sin| and cos for the quotient
   always_ff @(posedge clock) begin
      if (adv) begin
         nc_ff[0] <= rx_ff[N];
         nm_ff[0] <= ry_ff[N][63] ? (64'd0 - ry_ff[N]) : ry_ff[N];
      end
   end

   // scale cos and |sin| down together by powers of two until cos drops below 2^30
   for (genvar j = 0; j < NS; j++) begin : g_norm
      localparam int SH = 32 >> j;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (nc_ff[j] >= (64'd1 << (29 + SH))) begin
               nc_ff[j+1] <= nc_ff[j] >> SH;
               nm_ff[j+1] <= nm_ff[j] >> SH;
            end else begin
               nc_ff[j+1] <= nc_ff[j];
               nm_ff[j+1] <= nm_ff[j];
            end
         end
      end
   end

   // first long division: |sin| / cos, one quotient bit a stage
   always_ff @(posedge clock) begin
      if (adv) begin
         d1r_ff[0] <= nm_ff[NS][Q1+29:Q1];
         d1m_ff[0] <= nm_ff[NS][Q1-1:0];
         d1c_ff[0] <= nc_ff[NS][29:0];
         d1q_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < Q1; j++) begin : g_div1
      logic [30:0] t1, df1;
      logic        ge1;
      assign t1  = {d1r_ff[j], d1m_ff[j][Q1-1-j]};
      assign df1 = t1 - {1'b0, d1c_ff[j]};
      assign ge1 = (t1 >= {1'b0, d1c_ff[j]});
      always_ff @(posedge clock) begin
         if (adv) begin
            d1r_ff[j+1] <= ge1 ? df1[29:0] : t1[29:0];
            d1q_ff[j+1] <= {d1q_ff[j][Q1-2:0], ge1};
            d1m_ff[j+1] <= d1m_ff[j];
            d1c_ff[j+1] <= d1c_ff[j];
         end
      end
   end

   // scale quotient and remainder by the width, form the rounding numerator
   assign nsum = 55'(wr_ff) + (wq_ff[0] ? 55'(c2_ff) : 55'd0) + 55'(c2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         wq_ff     <= side_ff[S_M2-1].wd * d1q_ff[Q1];
         wr_ff     <= side_ff[S_M2-1].wd * d1r_ff[Q1];
         c2_ff     <= d1c_ff[Q1];
         d2r_ff[0] <= nsum[54:Q2];
         d2n_ff[0] <= nsum[Q2-1:0];
         d2d_ff[0] <= {c2_ff, 1'b0};
         d2q_ff[0] <= '0;
         wqh_ff[0] <= wq_ff[49:1];
      end
   end

   // second long division: numerator / 2cos
   for (genvar j = 0; j < Q2; j++) begin : g_div2
      logic [31:0] t2, df2;
      logic        ge2;
      assign t2  = {d2r_ff[j], d2n_ff[j][Q2-1-j]};
      assign df2 = t2 - {1'b0, d2d_ff[j]};
      assign ge2 = (t2 >= {1'b0, d2d_ff[j]});
      always_ff @(posedge clock) begin
         if (adv) begin
            d2r_ff[j+1] <= ge2 ? df2[30:0] : t2[30:0];
            d2q_ff[j+1] <= {d2q_ff[j][Q2-2:0], ge2};
            d2n_ff[j+1] <= d2n_ff[j];
            d2d_ff[j+1] <= d2d_ff[j];
            wqh_ff[j+1] <= wqh_ff[j];
         end
      end
   end

   // offset, signed mass, then clamp to the window
   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff <= 50'(wqh_ff[Q2]) + 50'(d2q_ff[Q2]);
         if (side_ff[S_MA-1].neg) begin
            ms_ff <= $signed({28'd0, side_ff[S_MA-1].pk}) - $signed({2'd0, off_ff});
         end else begin
            ms_ff <= $signed({28'd0, side_ff[S_MA-1].pk}) + $signed({2'd0, off_ff});
         end
         if (side_ff[S_CL-1].early) begin
            fin_mass_ff <= side_ff[S_CL-1].e_mass;
            fin_stat_ff <= side_ff[S_CL-1].e_stat;
         end else if (ms_ff < $signed({28'd0, side_ff[S_CL-1].mn})) begin
            fin_mass_ff <= side_ff[S_CL-1].mn;
            fin_stat_ff <= bwms_pkg::ST_SAT;
         end else if (ms_ff > $signed({28'd0, side_ff[S_CL-1].mx})) begin
            fin_mass_ff <= side_ff[S_CL-1].mx;
            fin_stat_ff <= bwms_pkg::ST_SAT;
         end else begin
            fin_mass_ff <= ms_ff[23:0];
            fin_stat_ff <= bwms_pkg::ST_OK;
         end
      end
   end

   // two-entry output queue
   always_ff @(posedge clock) begin
      if (push) begin
         qm_ff[wp_ff] <= fin_mass_ff;
         qs_ff[wp_ff] <= fin_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_ch.valid        = (cnt_ff != 2'd0);
   assign rsp_ch.sampled_mass = qm_ff[rd_ff];
   assign rsp_ch.status       = qs_ff[rd_ff];

endmodule

`default_nettype wire

// ===== design/bwms_checker.sv =====
// Port-level checker for the mass sampler, bound to the top level below.
// Depends on breit_wigner_mass_sampler_assert.svh and breit_wigner_mass_sampler.
`default_nettype none

`include "breit_wigner_mass_sampler_assert.svh"

module bwms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_mass,
   input wire logic [1:0]  rsp_status
);

   // a stalled response word stays put
   `BWMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `BWMS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_mass) && $stable(rsp_status), "response changed while stalled")

   // input stalls only behind a full output queue
   `BWMS_ASSERT_NOW(a_stall_full, !req_ready, rsp_valid, "stall with no response pending")
   `BWMS_ASSERT_NOW(a_stall_cause, $fell(req_ready), $past(rsp_valid && !rsp_ready), "stall without backpressure")

endmodule

bind breit_wigner_mass_sampler bwms_checker u_bwms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_mass   (rsp_ch.sampled_mass),
   .rsp_status (rsp_ch.status)
);

`default_nettype wire

// ===== verif/tb_breit_wigner_mass_sampler.sv =====
// Self-checking testbench for the truncated Breit-Wigner mass sampler.
// Depends on bwms_pkg, bwms_if and breit_wigner_mass_sampler; predicts each response word
// with a bit-exact CORDIC model and checks it in order against the block's output.
`default_nettype none

module tb_breit_wigner_mass_sampler;

   localparam int FRAC    = 20;
   localparam int STEPS   = 24;
   localparam int LATENCY = 2 * STEPS + 70;
   localparam int N_RAND  = 1800;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [23:0] mn;
      logic [23:0] mx;
      logic [23:0] pk;
      logic [23:0] wd;
      logic [23:0] u;
   } draw_word_type;

   typedef struct packed {
      logic [23:0]          mass;
      bwms_pkg::status_type stat;
   } mass_word_type;

   logic clock;
   logic reset;
   bwms_req_if req_ch ();
   bwms_rsp_if rsp_ch ();

   breit_wigner_mass_sampler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   draw_word_type pending_draws[$];
   mass_word_type expected_masses[$];
   longint        atan_tab[STEPS];
   longint        half_pi;
   int            mismatch_count;
   longint        cycle_count;
   bit            stimulus_done;
   bit            calm_phase;
   int            req_gap;
   int            rsp_gap;
   int            hold_cycles;
   int            accepted_count;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // arctangent table and pi/2 in angle units
   initial begin
      for (int i = 0; i < STEPS; i++) atan_tab[i] = longint'(bwms_pkg::atan_entry(i, FRAC));
      half_pi = longint'((bwms_pkg::PI_QUARTER_Q62 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
   end

   function automatic longint cordic_vector(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      return z;
   endfunction

   // predict the sampled mass for one request word
   function automatic mass_word_type sample_mass(draw_word_type d);
      mass_word_type r;
      longint mn, mx, pk, wd, a, b, span, theta, x, y, z, dx, dy, mass;
      longint unsigned sp, u, mag, cc, qi, rem, wq, off;
      bit neg;
      mn = d.mn; mx = d.mx; pk = d.pk; wd = d.wd; u = d.u;
      r.stat = bwms_pkg::ST_OK;
      if (mx <= mn) begin
         r.mass = d.mx; r.stat = bwms_pkg::ST_EMPTY;
         return r;
      end
      if (wd == 0) begin
         mass = pk < mn ? mn : (pk > mx ? mx : pk);
         r.mass = mass[23:0]; r.stat = bwms_pkg::ST_ZERO_W;
         return r;
      end
      a = cordic_vector(2 * (mn - pk) * (64'sd1 << 30), wd * (64'sd1 << 30));
      b = cordic_vector(2 * (mx - pk) * (64'sd1 << 30), wd * (64'sd1 << 30));
      span = b - a;
      if (half_pi - a < span) span = half_pi - a;
      if (span < 0) span = 0;
      sp = span;
      theta = longint'((sp * (u >> 12) + ((sp * (u & 64'hFFF)) >> 12)) >> 12);
      // rotation from (2^60, 0)
      x = 64'sd1 << 60; y = 0; z = a + theta;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      neg = y < 0;
      mag = neg ? longint'(-y) : y;
      if (x <= 0) begin
         mass = neg ? mn : mx; r.stat = bwms_pkg::ST_SAT;
      end else begin
         cc = x;
         while (cc >= (64'd1 << 30)) begin
            cc >>= 1; mag >>= 1;
         end
         if (mag >= (cc << 26)) begin
            mass = neg ? mn : mx; r.stat = bwms_pkg::ST_SAT;
         end else begin
            qi = mag / cc;
            rem = mag % cc;
            wq = longint'(wd) * qi;
            off = (wq >> 1) + (((wq & 1) * cc + longint'(wd) * rem + cc) / (2 * cc));
            mass = neg ? pk - longint'(off) : pk + longint'(off);
            if (mass < mn) begin
               mass = mn; r.stat = bwms_pkg::ST_SAT;
            end else if (mass > mx) begin
               mass = mx; r.stat = bwms_pkg::ST_SAT;
            end
         end
      end
      r.mass = mass[23:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
   endtask

   function automatic draw_word_type make_draw(int unsigned m, int unsigned n,
                                               int unsigned p, int unsigned w,
                                               int unsigned u);
      draw_word_type d;
      d.mn = m[23:0]; d.mx = n[23:0]; d.pk = p[23:0]; d.wd = w[23:0]; d.u = u[23:0];
      return d;
   endfunction

   // random well-formed window around a peak, with some noise
   function automatic draw_word_type random_draw();
      draw_word_type d;
      int unsigned lo, hi, kind;
      kind = $urandom_range(0, 19);
      d = make_draw($urandom, $urandom, $urandom, $urandom, $urandom);
      if (kind < 15) begin
         lo = $urandom_range(0, 24'hFFFFFE);
         hi = $urandom_range(lo + 1, 24'hFFFFFF);
         d.mn = lo[23:0]; d.mx = hi[23:0];
         d.pk = (kind < 10) ? 24'($urandom_range(lo, hi)) : 24'($urandom);
         d.wd = (kind < 8) ? 24'($urandom_range(1, 24'h3FFFF)) :
                24'($urandom_range(1, 24'hFFFFFF));
      end else if (kind == 15) begin
         d.wd = 24'd0;
      end else if (kind == 16) begin
         d.mx = d.mn;
      end
      return d;
   endfunction

   // stimulus
   initial begin
      draw_word_type d;
      mismatch_count = 0;
      stimulus_done = 1'b0;
      calm_phase = 1'b0;
      pending_draws.push_back(make_draw(0, 0, 0, 0, 0));
      pending_draws.push_back(make_draw(24'h100000, 24'h100000, 1, 1, 1));
      pending_draws.push_back(make_draw(24'h200000, 24'h100000, 1, 1, 1));
      pending_draws.push_back(make_draw(24'h100000, 24'h200000, 24'h180000, 0, 5));
      pending_draws.push_back(make_draw(24'h100000, 24'h200000, 24'h080000, 0, 5));
      pending_draws.push_back(make_draw(24'h100000, 24'h200000, 24'hF00000, 0, 5));
      pending_draws.push_back(make_draw(0, 24'hFFFFFF, 24'h800000, 24'h100000, 0));
      pending_draws.push_back(make_draw(0, 24'hFFFFFF, 24'h800000, 24'h100000, 24'hFFFFFF));
      pending_draws.push_back(make_draw(0, 24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'h800000));
      pending_draws.push_back(make_draw(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      pending_draws.push_back(make_draw(0, 24'hFFFFFF, 0, 1, 24'hFFFFFF));
      pending_draws.push_back(make_draw(24'h800000, 24'h800010, 0, 1, 24'h7FFFFF));
      pending_draws.push_back(make_draw(24'h100000, 24'h200000, 24'hFFFFFF, 1, 24'hFFFFFF));
      pending_draws.push_back(make_draw(24'h100000, 24'h100001, 24'h100000, 24'h10, 24'h555555));
      pending_draws.push_back(make_draw(0, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hAAAAAA));
      for (int i = 0; i < N_RAND; i++) begin
         d = random_draw();
         pending_draws.push_back(d);
      end
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_draws.size() < 200);
      calm_phase = 1'b1;
      wait (pending_draws.size() == 0 && !req_ch.valid);
      wait (expected_masses.size() == 0);
      repeat (LATENCY) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // request driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.min_mass = '0; req_ch.max_mass = '0; req_ch.peak_mass = '0;
      req_ch.full_width = '0; req_ch.uniform_draw = '0;
      req_gap = 0;
      accepted_count = 0;
   end

   always @(posedge clock) begin
      draw_word_type d;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            d = {req_ch.min_mass, req_ch.max_mass, req_ch.peak_mass, req_ch.full_width,
                 req_ch.uniform_draw};
            expected_masses.push_back(sample_mass(d));
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 3);
               req_ch.valid <= 1'b0;
            end else if (pending_draws.size() > 0) begin
               d = pending_draws.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.min_mass     <= d.mn;
               req_ch.max_mass     <= d.mx;
               req_ch.peak_mass    <= d.pk;
               req_ch.full_width   <= d.wd;
               req_ch.uniform_draw <= d.u;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response stall, with one long hold-off partway through
   initial begin
      rsp_ch.ready = 1'b0;
      rsp_gap = 0;
      hold_cycles = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (accepted_count >= 400 && hold_cycles == 0) begin
         hold_cycles = 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0 && hold_cycles < 600) begin
         hold_cycles++;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 3);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      mass_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_masses.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.sampled_mass, '0);
         end else begin
            want = expected_masses.pop_front();
            if (rsp_ch.sampled_mass !== want.mass)
               report_mismatch("sampled_mass", rsp_ch.sampled_mass, want.mass);
            if (rsp_ch.status !== want.stat)
               report_mismatch("status", 24'(rsp_ch.status), 24'(want.stat));
         end
      end
   end

   // end of run and timeout
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (stimulus_done) begin
         if (mismatch_count == 0 && expected_masses.size() == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
         $finish;
      end else if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/bwms_pkg.sv
design/bwms_if.sv
design/breit_wigner_mass_sampler.sv
design/bwms_checker.sv
verif/tb_breit_wigner_mass_sampler.sv
